### src/qbsm_pkg.sv
// Shared types, constants and mode decode functions for the QAM byte-to-symbol mapper.
package qbsm_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned ORDER_W    = 3;
  localparam int unsigned GATHER_MAX = 7;
  localparam int unsigned GROUP_W    = GATHER_MAX * BYTE_W;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_CNT_W = 2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_QAM_ORDER = '0;
  localparam logic [ORDER_W-1:0]   ORDER_RESET   = 3'd2;

  localparam logic [ORDER_W-1:0] QAM16  = 3'd0;
  localparam logic [ORDER_W-1:0] QAM32  = 3'd1;
  localparam logic [ORDER_W-1:0] QAM64  = 3'd2;
  localparam logic [ORDER_W-1:0] QAM128 = 3'd3;
  localparam logic [ORDER_W-1:0] QAM256 = 3'd4;

  // One complete group, left-aligned so that the first bit sits at the MSB.
  typedef struct packed {
    logic [ORDER_W-1:0] mode;
    logic [GROUP_W-1:0] bits;
  } qbsm_grp_t;

  // Bits per symbol; the unused codes behave as 256QAM.
  function automatic logic [SHIFT_W-1:0] qbsm_sym_bits(input logic [ORDER_W-1:0] mode);
    logic [SHIFT_W-1:0] r;
    case (mode)
      QAM16:   r = 4'd4;
      QAM32:   r = 4'd5;
      QAM64:   r = 4'd6;
      QAM128:  r = 4'd7;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] qbsm_grp_bytes(input logic [ORDER_W-1:0] mode);
    logic [CNT_W-1:0] r;
    case (mode)
      QAM32:   r = 3'd5;
      QAM64:   r = 3'd3;
      QAM128:  r = 3'd7;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  // Symbols per group, minus one.
  function automatic logic [CNT_W-1:0] qbsm_grp_syms_m1(input logic [ORDER_W-1:0] mode);
    logic [CNT_W-1:0] r;
    case (mode)
      QAM16:   r = 3'd1;
      QAM32:   r = 3'd7;
      QAM64:   r = 3'd3;
      QAM128:  r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Moves a group held in the low bits of the word up to the MSB end.
  function automatic logic [GROUP_W-1:0] qbsm_align(input logic [ORDER_W-1:0] mode,
                                                    input logic [GROUP_W-1:0] word);
    logic [GROUP_W-1:0] r;
    case (mode)
      QAM32:   r = word << 16;
      QAM64:   r = word << 32;
      QAM128:  r = word;
      default: r = word << 48;
    endcase
    return r;
  endfunction

endpackage

### src/qbsm_if.sv
// Valid/ready channel interfaces for the byte input and the symbol output.
interface qbsm_byte_if
  import qbsm_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
  modport monitor (input valid, input data_byte, input ready);
endinterface

interface qbsm_sym_if
  import qbsm_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_index;
  logic             group_last;

  modport source (output valid, output symbol_index, output group_last, input ready);
  modport sink (input valid, input symbol_index, input group_last, output ready);
  modport monitor (input valid, input symbol_index, input group_last, input ready);
endinterface

### src/qbsm_front.sv
// Front end: gathers incoming bytes into groups and pushes each complete group.
module qbsm_front
  import qbsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ORDER_W-1:0] qam_order_i,
  input  logic               clear_i,
  input  logic               in_valid_i,
  input  logic [BYTE_W-1:0]  in_byte_i,
  output logic               in_ready_o,
  output logic               push_valid_o,
  output qbsm_grp_t          push_grp_o,
  input  logic               push_ready_i
);

  logic [GROUP_W-BYTE_W-1:0] gather_q, gather_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [GROUP_W-1:0]        word;
  logic [CNT_W-1:0]          count_inc;
  logic                      accept;
  logic                      done;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign word       = {gather_q, in_byte_i};
  assign count_inc  = count_q + 3'd1;
  assign done       = count_inc >= qbsm_grp_bytes(qam_order_i);

  always_comb begin
    gather_d = gather_q;
    count_d  = count_q;
    if (accept) begin
      gather_d = word[GROUP_W-BYTE_W-1:0];
      count_d  = done ? '0 : count_inc;
    end
    if (clear_i) begin
      count_d = '0;
    end
  end

  assign push_valid_o    = accept && done;
  assign push_grp_o.mode = qam_order_i;
  assign push_grp_o.bits = qbsm_align(qam_order_i, word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gather_q <= gather_d;
  end

endmodule

### src/qbsm_fifo.sv
// Two-entry group queue between the front and back ends.
module qbsm_fifo
  import qbsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  qbsm_grp_t push_grp_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output qbsm_grp_t pop_grp_o,
  input  logic      pop_i
);

  qbsm_grp_t             entry_q [FIFO_DEPTH];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign push_ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_grp_o    = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_grp_i;
    end
  end

endmodule

### src/qbsm_back.sv
// Back end: cuts each group into symbols, one a cycle unless the output stalls, with differential quadrant coding.
module qbsm_back
  import qbsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             grp_valid_i,
  input  qbsm_grp_t        grp_i,
  output logic             grp_pop_o,
  output logic             out_valid_o,
  output logic [SYM_W-1:0] out_symbol_o,
  output logic             out_last_o,
  input  logic             out_ready_i
);

  logic               busy_q, busy_d;
  logic [GROUP_W-1:0] data_q, data_d;
  logic [ORDER_W-1:0] mode_q, mode_d;
  logic [CNT_W-1:0]   left_q, left_d;
  logic [1:0]         quad_q, quad_d;
  logic               oval_q, oval_d;
  logic [SYM_W-1:0]   osym_q, osym_d;
  logic               olast_q, olast_d;
  logic               advance, last;
  logic [SHIFT_W-1:0] q_bits;
  logic [1:0]         ab, iq;
  logic [SYM_W-1:0]   raw;

  assign q_bits  = qbsm_sym_bits(mode_q);
  assign advance = busy_q && (!oval_q || out_ready_i);
  assign last    = left_q == '0;
  assign ab      = data_q[GROUP_W-1 -: 2];

  // Same quadrant bits rotate straight through, differing ones swap the references.
  always_comb begin
    if (ab[1] == ab[0]) begin
      iq = {ab[1] ^ quad_q[1], ab[0] ^ quad_q[0]};
    end else begin
      iq = {ab[1] ^ quad_q[0], ab[0] ^ quad_q[1]};
    end
  end

  assign raw = {iq, data_q[GROUP_W-3 -: SYM_W-2]} >> (4'd8 - q_bits);

  always_comb begin
    busy_d    = busy_q;
    data_d    = data_q;
    mode_d    = mode_q;
    left_d    = left_q;
    quad_d    = quad_q;
    oval_d    = oval_q;
    osym_d    = osym_q;
    olast_d   = olast_q;
    grp_pop_o = 1'b0;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    if (advance) begin
      oval_d  = 1'b1;
      osym_d  = raw;
      olast_d = last;
      quad_d  = iq;
      data_d  = data_q << q_bits;
      left_d  = left_q - 3'd1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (grp_valid_i && (!busy_q || (advance && last))) begin
      grp_pop_o = 1'b1;
      busy_d    = 1'b1;
      data_d    = grp_i.bits;
      mode_d    = grp_i.mode;
      left_d    = qbsm_grp_syms_m1(grp_i.mode);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      quad_q <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      quad_q <= quad_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    mode_q  <= mode_d;
    left_q  <= left_d;
    osym_q  <= osym_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = oval_q;
  assign out_symbol_o = osym_q;
  assign out_last_o   = olast_q;

endmodule

### src/qam_byte_to_symbol_mapper.sv
// Top level of the QAM byte-to-symbol mapper with differential quadrant coding.
// The group completed by a byte is registered in the queue, then in the back-end group
// register, and its first symbol in the output register. Throughput: one symbol per cycle
// while the output is not stalled; the single symbol slicer in the back end sets this.
// Reset (rst_ni low, asynchronous) empties the queue, clears the gather count and
// the quadrant bits, and sets qam_order to 64QAM.
module qam_byte_to_symbol_mapper
  import qbsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  qbsm_byte_if.sink             byte_i,
  qbsm_sym_if.source            sym_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ORDER_W-1:0] order_q, order_d;
  logic               cfg_wr;
  logic               hit;
  logic               push_valid, push_ready;
  qbsm_grp_t          push_grp;
  logic               pop_valid, pop;
  qbsm_grp_t          pop_grp;

  // The configuration port never waits. A write to qam_order also throws away any
  // partly gathered group; the quadrant reference is left alone.
  assign pready = 1'b1;
  assign hit    = paddr[APB_ADDR_W-1:2] == REG_QAM_ORDER;
  assign cfg_wr = psel && penable && pwrite && hit;
  assign prdata = hit ? APB_DATA_W'(order_q) : '0;

  always_comb begin
    order_d = order_q;
    if (cfg_wr) begin
      order_d = pwdata[ORDER_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else begin
      order_q <= order_d;
    end
  end

  // The front end takes a byte every cycle while the queue has room, and hands
  // over a group only once its final byte has arrived.
  qbsm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qam_order_i  (order_q),
    .clear_i      (cfg_wr),
    .in_valid_i   (byte_i.valid),
    .in_byte_i    (byte_i.data_byte),
    .in_ready_o   (byte_i.ready),
    .push_valid_o (push_valid),
    .push_grp_o   (push_grp),
    .push_ready_i (push_ready)
  );

  // The queue carries the group together with the mode it was gathered under.
  qbsm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_grp_i   (push_grp),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_grp_o    (pop_grp),
    .pop_i        (pop)
  );

  // The back end loads the next group in the same cycle as it emits the last
  // symbol of the current one, so symbols of queued groups leave without gaps between groups.
  qbsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grp_valid_i  (pop_valid),
    .grp_i        (pop_grp),
    .grp_pop_o    (pop),
    .out_valid_o  (sym_o.valid),
    .out_symbol_o (sym_o.symbol_index),
    .out_last_o   (sym_o.group_last),
    .out_ready_i  (sym_o.ready)
  );

endmodule

### src/qbsm_checker.sv
// Port-level assertions for the mapper, bound to the top level.
module qbsm_checker
  import qbsm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  sym_valid_i,
  input logic                  sym_ready_i,
  input logic [SYM_W-1:0]      sym_index_i,
  input logic                  sym_last_i,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] prdata
);

  logic order_visible;

  assign order_visible = paddr[APB_ADDR_W-1:2] == REG_QAM_ORDER;

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !sym_valid_i)
    else $error("symbol valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_valid_i && !sym_ready_i |=> sym_valid_i && $stable(sym_index_i)
                                    && $stable(sym_last_i))
    else $error("stalled symbol transaction changed");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_valid_i && order_visible && prdata[ORDER_W-1:0] >= QAM256 |-> sym_last_i)
    else $error("256QAM symbol not marked last");

  a_pair_16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_valid_i && sym_ready_i && !sym_last_i && order_visible
    && prdata[ORDER_W-1:0] == QAM16 |=> !sym_valid_i || sym_last_i)
    else $error("16QAM group not closed on second symbol");

endmodule

bind qam_byte_to_symbol_mapper qbsm_checker u_qbsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .sym_valid_i (sym_o.valid),
  .sym_ready_i (sym_o.ready),
  .sym_index_i (sym_o.symbol_index),
  .sym_last_i  (sym_o.group_last),
  .paddr       (paddr),
  .prdata      (prdata)
);
